>>> src/scint_pkg.sv
// Package for the surface coverage integrator: constants, datapath command and
// status types, and the controller state encoding. No dependencies.
package scint_pkg;

  localparam int EXP_ITERATIONS = 24;
  localparam int IW = $clog2(EXP_ITERATIONS + 1);

  localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
  localparam logic [31:0] HALF_Q32   = 32'h8000_0000;
  localparam logic [30:0] COV_ONE    = 31'h4000_0000;
  localparam logic [62:0] DEPTH_MAX  = {63{1'b1}};
  localparam logic [47:0] TIME_MAX   = {48{1'b1}};
  localparam logic [31:0] LAYER_INIT = 32'h0001_0000;

  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_MUL_KT, OP_MUL_TH, OP_INT0, OP_X, OP_SER_INIT,
    OP_MUL_TF, OP_DIV_TI, OP_SER_ACC, OP_SER_END, OP_MUL_HH, OP_E1,
    OP_MUL_EE, OP_E_UPD, OP_DIV_EQ, OP_EQ, OP_MUL_EQT, OP_EQT, OP_MUL_DEC,
    OP_DEC, OP_MUL_OME, OP_DIV_TRM, OP_INT, OP_MUL_CI, OP_AMT1, OP_MUL_ST,
    OP_AMT2, OP_MUL_AL, OP_RINC, OP_MUL_GT, OP_GT, OP_DINC, OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t        op;
    logic [IW-1:0] iter;
    logic          sel;
  } dp_cmd_t;

  typedef struct packed {
    logic       k_zero;
    logic       e_zero;
    logic [4:0] x_n;
    logic       unit_done;
    logic       out_full;
  } dp_stat_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_WAIT, ST_KT, ST_INT0, ST_X, ST_SINIT, ST_SMUL, ST_SDIV,
    ST_SACC, ST_SEND, ST_HSQ, ST_E1, ST_PMUL, ST_PUPD, ST_EQD, ST_EQ,
    ST_EQTM, ST_EQT, ST_DECM, ST_DEC, ST_OMEM, ST_TRMD, ST_INT, ST_CIM,
    ST_AMT1, ST_STM, ST_AMT2, ST_ALM, ST_RINC, ST_GTM, ST_GT, ST_GLM,
    ST_DINC, ST_FIN
  } ctl_state_t;

endpackage

>>> src/scint_mul.sv
// Shared multiplier: 64 x 35 bit unsigned product in two 32-bit halves.
// Uses scint_pkg only for the common import style.
module scint_mul import scint_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [34:0] b,
  output logic [98:0] prod,
  output logic        done
);

  logic [1:0]  ph_r;
  logic        done_r;
  logic [31:0] ahi_r;
  logic [34:0] b_r;
  logic [66:0] p_r;
  logic [98:0] prod_r;
  logic [31:0] mx;
  logic [34:0] my;

  assign mx = start ? a[31:0] : ahi_r;
  assign my = start ? b : b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= '0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= {ph_r[0], start};
      done_r <= ph_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ahi_r <= a[63:32];
      b_r   <= b;
    end
    if (start || ph_r[0]) begin
      p_r <= 67'(mx) * 67'(my);
    end
    if (ph_r[0]) begin
      prod_r <= {32'b0, p_r};
    end else if (ph_r[1]) begin
      prod_r <= prod_r + {p_r, 32'b0};
    end
  end

  assign prod = prod_r;
  assign done = done_r;

endmodule

>>> src/scint_div.sv
// Shared restoring divider: 64-bit dividend, 35-bit divisor, one quotient bit
// per cycle. Uses scint_pkg only for the common import style.
module scint_div import scint_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [34:0] den,
  output logic [63:0] quot,
  output logic        done
);

  localparam logic [6:0] DIV_STEPS = 7'd64;

  logic [6:0]  cnt_r;
  logic        done_r;
  logic [63:0] q_r;
  logic [34:0] rem_r;
  logic [34:0] den_r;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        fits;

  assign trial = {rem_r, q_r[63]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == 7'd1) && !start;
      if (start) begin
        cnt_r <= DIV_STEPS;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? diff[34:0] : trial[34:0];
      q_r   <= {q_r[62:0], fits};
    end
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

>>> src/scint_dp.sv
// Datapath: phase operands, coverage and depth accumulators, output register,
// and the shared multiplier and divider. Depends on scint_pkg, scint_mul, scint_div.
module scint_dp import scint_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  dp_cmd_t       cmd,
  input  logic          in_start,
  input  logic [191:0]  in_data,
  input  logic          cfg_wr_en,
  input  logic [31:0]   cfg_wr_data,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [271:0]  out_data,
  output logic          out_sat,
  output dp_stat_t      stat
);

  logic [31:0] layer_r, t_r, a_r, c_r, s_r, g_r, f_r, farg_r;
  logic [34:0] k_r;
  logic [32:0] term_r, e_r, e1_r;
  logic signed [35:0] sum_r;
  logic [30:0] eq_r, mag_r, theta_r;
  logic        ge_r;
  logic [46:0] eqt_r;
  logic [48:0] integral_r;
  logic [63:0] amt_r;
  logic [62:0] removed_r, deposited_r;
  logic [47:0] elapsed_r;
  logic        ovf_r;
  logic        out_valid_r;
  logic [271:0] out_data_r;
  logic        out_sat_r;

  logic        mul_start, div_start, mul_done, div_done;
  logic [63:0] mul_a, div_num, quot;
  logic [34:0] mul_b, div_den;
  logic [98:0] prod;

  logic [32:0] ser_clamp;
  logic signed [35:0] ser_step;
  logic [30:0] q31, mag_new;
  logic        ge_new;
  logic [30:0] dec;
  logic [31:0] theta_up;
  logic [30:0] theta_new;
  logic [47:0] term48, eqt48;
  logic [48:0] int_new;
  logic        amt1_over;
  logic [63:0] amt1_val;
  logic [64:0] amt2_sum;
  logic [63:0] rem_sum, dep_sum;
  logic [48:0] el_sum;
  logic [47:0] el_new;
  logic [63:0] net;

  scint_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .prod(prod), .done(mul_done)
  );

  scint_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .quot(quot), .done(div_done)
  );

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      OP_MUL_KT:  begin mul_start = 1'b1; mul_a = {32'b0, t_r}; mul_b = k_r; end
      OP_MUL_TH:  begin mul_start = 1'b1; mul_a = {33'b0, theta_r}; mul_b = {3'b0, t_r}; end
      OP_MUL_TF:  begin mul_start = 1'b1; mul_a = {32'b0, farg_r}; mul_b = {2'b0, term_r}; end
      OP_MUL_HH:  begin mul_start = 1'b1; mul_a = {31'b0, e1_r}; mul_b = {2'b0, e1_r}; end
      OP_MUL_EE:  begin mul_start = 1'b1; mul_a = {31'b0, e1_r}; mul_b = {2'b0, e_r}; end
      OP_MUL_EQT: begin mul_start = 1'b1; mul_a = {33'b0, eq_r}; mul_b = {3'b0, t_r}; end
      OP_MUL_DEC: begin mul_start = 1'b1; mul_a = {33'b0, mag_r}; mul_b = {2'b0, e_r}; end
      OP_MUL_OME: begin
        mul_start = 1'b1;
        mul_a     = {33'b0, mag_r};
        mul_b     = {2'b0, ONE_Q32 - e_r};
      end
      OP_MUL_CI:  begin mul_start = 1'b1; mul_a = {15'b0, integral_r}; mul_b = {3'b0, c_r}; end
      OP_MUL_ST:  begin mul_start = 1'b1; mul_a = {32'b0, s_r}; mul_b = {3'b0, t_r}; end
      OP_MUL_AL:  begin mul_start = 1'b1; mul_a = amt_r; mul_b = {3'b0, layer_r}; end
      OP_MUL_GT:  begin mul_start = 1'b1; mul_a = {32'b0, g_r}; mul_b = {3'b0, t_r}; end
      OP_DIV_TI:  begin
        div_start = 1'b1;
        div_num   = {32'b0, prod[63:32]};
        div_den   = {{(35 - IW){1'b0}}, cmd.iter};
      end
      OP_DIV_EQ:  begin div_start = 1'b1; div_num = {2'b0, a_r, 30'b0}; div_den = k_r; end
      OP_DIV_TRM: begin div_start = 1'b1; div_num = prod[63:0]; div_den = k_r; end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (sum_r[35]) begin
      ser_clamp = '0;
    end else if (sum_r > $signed({3'b0, ONE_Q32})) begin
      ser_clamp = ONE_Q32;
    end else begin
      ser_clamp = sum_r[32:0];
    end
    ser_step = cmd.iter[0] ? sum_r - $signed({3'b0, quot[32:0]})
                           : sum_r + $signed({3'b0, quot[32:0]});

    q31     = quot[30:0];
    ge_new  = theta_r >= q31;
    mag_new = ge_new ? theta_r - q31 : q31 - theta_r;

    dec      = prod[62:32];
    theta_up = {1'b0, eq_r} + {1'b0, dec};
    if (ge_r) begin
      theta_new = (theta_up > {1'b0, COV_ONE}) ? COV_ONE : theta_up[30:0];
    end else begin
      theta_new = eq_r - dec;
    end

    term48 = quot[63:16];
    eqt48  = {1'b0, eqt_r};
    if (ge_r) begin
      int_new = {1'b0, eqt48} + {1'b0, term48};
    end else if (eqt48 >= term48) begin
      int_new = {1'b0, eqt48 - term48};
    end else begin
      int_new = '0;
    end

    amt1_over = |prod[98:78];
    amt1_val  = amt1_over ? {64{1'b1}} : prod[77:14];
    amt2_sum  = {1'b0, amt_r} + {1'b0, prod[63:0]};
    rem_sum   = {1'b0, removed_r} + {16'b0, prod[95:48]};
    dep_sum   = {1'b0, deposited_r} + {16'b0, prod[95:48]};
    el_sum    = {1'b0, elapsed_r} + {17'b0, t_r};
    el_new    = el_sum[48] ? TIME_MAX : el_sum[47:0];
    net       = {1'b0, removed_r} - {1'b0, deposited_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_r     <= LAYER_INIT;
      theta_r     <= '0;
      removed_r   <= '0;
      deposited_r <= '0;
      elapsed_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        layer_r <= cfg_wr_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          if (in_start) begin
            theta_r     <= '0;
            removed_r   <= '0;
            deposited_r <= '0;
            elapsed_r   <= '0;
            ovf_r       <= 1'b0;
          end
        end
        OP_DEC: theta_r <= theta_new;
        OP_AMT1: ovf_r <= ovf_r | amt1_over;
        OP_AMT2: ovf_r <= ovf_r | amt2_sum[64];
        OP_RINC: begin
          removed_r <= rem_sum[63] ? DEPTH_MAX : rem_sum[62:0];
          ovf_r     <= ovf_r | rem_sum[63];
        end
        OP_DINC: begin
          deposited_r <= dep_sum[63] ? DEPTH_MAX : dep_sum[62:0];
          ovf_r       <= ovf_r | dep_sum[63];
        end
        OP_FIN: begin
          elapsed_r   <= el_new;
          ovf_r       <= ovf_r | el_sum[48];
          out_valid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        t_r <= in_data[31:0];
        a_r <= in_data[63:32];
        c_r <= in_data[127:96];
        s_r <= in_data[159:128];
        g_r <= in_data[191:160];
        k_r <= 35'(in_data[63:32]) + 35'(in_data[95:64]) + 35'(in_data[127:96])
             + 35'(in_data[159:128]) + 35'(in_data[191:160]);
      end
      OP_INT0: integral_r <= {2'b0, prod[62:16]};
      OP_X: begin
        f_r <= prod[31:0];
        e_r <= '0;
      end
      OP_SER_INIT: begin
        sum_r  <= $signed({3'b0, ONE_Q32});
        term_r <= ONE_Q32;
        farg_r <= cmd.sel ? f_r : HALF_Q32;
      end
      OP_SER_ACC: begin
        term_r <= quot[32:0];
        sum_r  <= ser_step;
      end
      OP_SER_END: begin
        if (cmd.sel) begin
          e_r <= ser_clamp;
        end else begin
          e1_r <= ser_clamp;
        end
      end
      OP_E1:    e1_r <= {1'b0, prod[63:32]};
      OP_E_UPD: e_r <= {1'b0, prod[63:32]};
      OP_EQ: begin
        eq_r  <= q31;
        ge_r  <= ge_new;
        mag_r <= mag_new;
      end
      OP_EQT:  eqt_r <= prod[62:16];
      OP_INT:  integral_r <= int_new;
      OP_AMT1: amt_r <= amt1_val;
      OP_AMT2: amt_r <= amt2_sum[64] ? {64{1'b1}} : amt2_sum[63:0];
      OP_GT:   amt_r <= prod[63:0];
      OP_FIN: begin
        out_data_r <= {3'b0, net, deposited_r, removed_r, theta_r, el_new};
        out_sat_r  <= ovf_r | el_sum[48];
      end
      default: begin
      end
    endcase
  end

  assign stat.k_zero    = (k_r == '0);
  assign stat.e_zero    = |prod[98:37];
  assign stat.x_n       = prod[36:32];
  assign stat.unit_done = mul_done | div_done;
  assign stat.out_full  = out_valid_r & ~out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_sat   = out_sat_r;

endmodule

>>> src/scint_ctrl.sv
// Controller: sequences one phase through the shared multiplier and divider,
// including the exponential series and power loops. Depends on scint_pkg.
module scint_ctrl import scint_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dp_stat_t stat,
  output logic     in_ready,
  output dp_cmd_t  cmd
);

  ctl_state_t    state_r, state_nxt, ret_r, ret_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [4:0]    n_r, n_nxt;
  logic          sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      i_r     <= '0;
      n_r     <= '0;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      i_r     <= i_nxt;
      n_r     <= n_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    sel_nxt   = sel_r;
    cmd.op    = OP_NONE;
    cmd.iter  = i_r;
    cmd.sel   = sel_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_KT;
        end
      end
      ST_WAIT: begin
        if (stat.unit_done) begin
          state_nxt = ret_r;
        end
      end
      ST_KT: begin
        state_nxt = ST_WAIT;
        if (stat.k_zero) begin
          cmd.op  = OP_MUL_TH;
          ret_nxt = ST_INT0;
        end else begin
          cmd.op  = OP_MUL_KT;
          ret_nxt = ST_X;
        end
      end
      ST_INT0: begin
        cmd.op    = OP_INT0;
        state_nxt = ST_CIM;
      end
      ST_X: begin
        cmd.op = OP_X;
        if (stat.e_zero) begin
          state_nxt = ST_EQD;
        end else begin
          n_nxt     = stat.x_n;
          sel_nxt   = (stat.x_n == '0);
          state_nxt = ST_SINIT;
        end
      end
      ST_SINIT: begin
        cmd.op    = OP_SER_INIT;
        i_nxt     = IW'(1);
        state_nxt = ST_SMUL;
      end
      ST_SMUL: begin
        cmd.op    = OP_MUL_TF;
        ret_nxt   = ST_SDIV;
        state_nxt = ST_WAIT;
      end
      ST_SDIV: begin
        cmd.op    = OP_DIV_TI;
        ret_nxt   = ST_SACC;
        state_nxt = ST_WAIT;
      end
      ST_SACC: begin
        cmd.op = OP_SER_ACC;
        if (i_r == IW'(EXP_ITERATIONS)) begin
          state_nxt = ST_SEND;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = ST_SMUL;
        end
      end
      ST_SEND: begin
        cmd.op = OP_SER_END;
        if (!sel_r) begin
          state_nxt = ST_HSQ;
        end else if (n_r != '0) begin
          state_nxt = ST_PMUL;
        end else begin
          state_nxt = ST_EQD;
        end
      end
      ST_HSQ: begin
        cmd.op    = OP_MUL_HH;
        ret_nxt   = ST_E1;
        state_nxt = ST_WAIT;
      end
      ST_E1: begin
        cmd.op    = OP_E1;
        sel_nxt   = 1'b1;
        state_nxt = ST_SINIT;
      end
      ST_PMUL: begin
        cmd.op    = OP_MUL_EE;
        ret_nxt   = ST_PUPD;
        state_nxt = ST_WAIT;
      end
      ST_PUPD: begin
        cmd.op    = OP_E_UPD;
        n_nxt     = n_r - 5'd1;
        state_nxt = (n_r == 5'd1) ? ST_EQD : ST_PMUL;
      end
      ST_EQD: begin
        cmd.op    = OP_DIV_EQ;
        ret_nxt   = ST_EQ;
        state_nxt = ST_WAIT;
      end
      ST_EQ: begin
        cmd.op    = OP_EQ;
        state_nxt = ST_EQTM;
      end
      ST_EQTM: begin
        cmd.op    = OP_MUL_EQT;
        ret_nxt   = ST_EQT;
        state_nxt = ST_WAIT;
      end
      ST_EQT: begin
        cmd.op    = OP_EQT;
        state_nxt = ST_DECM;
      end
      ST_DECM: begin
        cmd.op    = OP_MUL_DEC;
        ret_nxt   = ST_DEC;
        state_nxt = ST_WAIT;
      end
      ST_DEC: begin
        cmd.op    = OP_DEC;
        state_nxt = ST_OMEM;
      end
      ST_OMEM: begin
        cmd.op    = OP_MUL_OME;
        ret_nxt   = ST_TRMD;
        state_nxt = ST_WAIT;
      end
      ST_TRMD: begin
        cmd.op    = OP_DIV_TRM;
        ret_nxt   = ST_INT;
        state_nxt = ST_WAIT;
      end
      ST_INT: begin
        cmd.op    = OP_INT;
        state_nxt = ST_CIM;
      end
      ST_CIM: begin
        cmd.op    = OP_MUL_CI;
        ret_nxt   = ST_AMT1;
        state_nxt = ST_WAIT;
      end
      ST_AMT1: begin
        cmd.op    = OP_AMT1;
        state_nxt = ST_STM;
      end
      ST_STM: begin
        cmd.op    = OP_MUL_ST;
        ret_nxt   = ST_AMT2;
        state_nxt = ST_WAIT;
      end
      ST_AMT2: begin
        cmd.op    = OP_AMT2;
        state_nxt = ST_ALM;
      end
      ST_ALM: begin
        cmd.op    = OP_MUL_AL;
        ret_nxt   = ST_RINC;
        state_nxt = ST_WAIT;
      end
      ST_RINC: begin
        cmd.op    = OP_RINC;
        state_nxt = ST_GTM;
      end
      ST_GTM: begin
        cmd.op    = OP_MUL_GT;
        ret_nxt   = ST_GT;
        state_nxt = ST_WAIT;
      end
      ST_GT: begin
        cmd.op    = OP_GT;
        state_nxt = ST_GLM;
      end
      ST_GLM: begin
        cmd.op    = OP_MUL_AL;
        ret_nxt   = ST_DINC;
        state_nxt = ST_WAIT;
      end
      ST_DINC: begin
        cmd.op    = OP_DINC;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.out_full) begin
          cmd.op    = OP_FIN;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/surface_coverage_integrator.sv
// Top level of the surface coverage integrator: controller plus datapath.
// Depends on scint_pkg, scint_ctrl, scint_dp.
//
//   channel | dir | ports                                   | per transfer
//   in      | in  | in_tvalid/in_tready/in_tdata/in_tuser   | one process phase
//   out     | out | out_tvalid/out_tready/out_tdata/out_tuser| cumulative snapshot
//   cfg     | in  | cfg_wr_en/cfg_wr_data                   | layer thickness write
//
// One phase at a time. Multiplies and divisions share one unit each.
// k zero: no exponential series. Otherwise the phase runs exponential series
// (none when k*t >= 32, one when its whole part n is zero, else two) and then
// a power loop of n multiplies.
// Reset is synchronous; the output register frees the input side while a
// snapshot waits, and a stalled result holds the controller before its update.
module surface_coverage_integrator import scint_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // duration, modify_rate, restore_rate, modified_etch_rate, bare_etch_rate,
  // deposit_rate (32 bits each, from bit 0)
  input  logic [191:0] in_tdata,
  // start_run
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // elapsed_time[47:0], coverage[78:48], removed_depth[141:79],
  // deposited_depth[204:142], net_depth[268:205], zero fill
  output logic [271:0] out_tdata,
  // saturated
  output logic         out_tuser,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  scint_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .stat(stat),
    .in_ready(in_tready), .cmd(cmd)
  );

  scint_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_start(in_tuser), .in_data(in_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data), .out_ready(out_tready),
    .out_valid(out_tvalid), .out_data(out_tdata), .out_sat(out_tuser), .stat(stat)
  );

  a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second phase taken while busy");

  a_cov_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[78:48] <= COV_ONE)
    else $error("coverage above one");

  a_net: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[268:205] ==
      ({1'b0, out_tdata[141:79]} - {1'b0, out_tdata[204:142]}))
    else $error("net depth mismatch");

endmodule
